@@ design/mbs_pkg.sv @@
// ----------------------------------------------------------------------------
// mbs_pkg: shared constants, codes and types of the maze backtracker step unit
// Field widths, event codes, register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package mbs_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_MAX_COLS    = 64;
   localparam int DEF_STACK_DEPTH = 1024;

   // Field widths.
   localparam int PICK_W      = 8;
   localparam int EV_W        = 3;
   localparam int COORD_W     = 6;
   localparam int OP_W        = 20;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = EV_W;

   localparam logic [OP_W-1:0] OP_MAX = {OP_W{1'b1}};

   // Request kinds.
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // Result event codes.
   localparam logic [EV_W-1:0] EV_CARVED    = 3'd0;
   localparam logic [EV_W-1:0] EV_BACKTRACK = 3'd1;
   localparam logic [EV_W-1:0] EV_DONE      = 3'd2;
   localparam logic [EV_W-1:0] EV_STARTED   = 3'd3;
   localparam logic [EV_W-1:0] EV_OVERFLOW  = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COL_COUNT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_ROW = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_COL = 2'd3;

   typedef struct packed {
      logic load_item;
      logic clear_step;
      logic scan_step;
      logic pop_read;
      logic commit_start;
      logic commit_done;
      logic commit_carve;
      logic commit_overflow;
      logic commit_pop;
   } mbs_cmd_type;

   typedef struct packed {
      logic action;
      logic finished;
      logic clear_last;
      logic scan_last;
      logic has_cand;
      logic stack_full;
      logic stack_empty;
      logic out_free;
   } mbs_sts_type;

   // Remainder of an 8-bit value by three. Since 4 is 1 mod 3, the 2-bit
   // digits are summed first, then the small sum is reduced.
   function automatic logic [1:0] mod3(input logic [PICK_W-1:0] v);
      logic [3:0] s;
      s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
      if (s >= 4'd6) s = s - 4'd6;
      if (s >= 4'd3) s = s - 4'd3;
      if (s >= 4'd3) s = s - 4'd3;
      return s[1:0];
   endfunction

endpackage

@@ design/mbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbs_ctrl: sequencing controller of the maze backtracker step unit
// Walks each accepted word through clear and start phases (start words) or
// scan, decide, pop and done phases (steps) and issues commands to the datapath.
// ----------------------------------------------------------------------------
module mbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mbs_pkg::mbs_sts_type sts,
   output mbs_pkg::mbs_cmd_type cmd
);
   import mbs_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_SCAN     = 3'd2;
   localparam logic [2:0] ST_DECIDE   = 3'd3;
   localparam logic [2:0] ST_POP      = 3'd4;
   localparam logic [2:0] ST_CLEAR    = 3'd5;
   localparam logic [2:0] ST_START    = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.action == ACT_START) begin
               state_in = ST_CLEAR;
            end else if (sts.finished) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.has_cand) begin
               if (sts.out_free) begin
                  cmd.commit_overflow = sts.stack_full;
                  cmd.commit_carve    = !sts.stack_full;
                  state_in            = ST_IDLE;
               end
            end else if (sts.stack_empty) begin
               if (sts.out_free) begin
                  cmd.commit_done = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.pop_read = 1'b1;
               state_in     = ST_POP;
            end
         end
         ST_POP: begin
            if (sts.out_free) begin
               cmd.commit_pop = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.out_free) begin
               cmd.commit_start = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit_done = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/mbs_datapath.sv @@
// ----------------------------------------------------------------------------
// mbs_datapath: storage and arithmetic of the maze backtracker step unit
// Holds the visited map and path stack memories, the current cell, the
// configuration registers, the neighbor logic and the result register.
// ----------------------------------------------------------------------------
module mbs_datapath #(
   parameter int MAX_ROWS    = mbs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS    = mbs_pkg::DEF_MAX_COLS,
   parameter int STACK_DEPTH = mbs_pkg::DEF_STACK_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mbs_pkg::mbs_cmd_type               cmd,
   output mbs_pkg::mbs_sts_type               sts,
   input  logic [mbs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [mbs_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mbs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [mbs_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [mbs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [mbs_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import mbs_pkg::*;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int CELL_W = $clog2(CELLS);
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int RC_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
   localparam int CMP_W  = ((RC_W > CSR_DATA_W) ? RC_W : CSR_DATA_W) + 2;
   localparam int STK_W  = ROW_W + COL_W;

   // Coordinates leave the block as their low six bits.
   function automatic logic [COORD_W-1:0] to_coord(input logic [CMP_W-1:0] v);
      return v[COORD_W-1:0];
   endfunction

   // Configuration registers.
   logic [CSR_DATA_W-1:0] rows_cfg_ff;
   logic [CSR_DATA_W-1:0] cols_cfg_ff;
   logic [COORD_W-1:0]    srow_cfg_ff;
   logic [COORD_W-1:0]    scol_cfg_ff;

   // Item and walk state.
   logic                action_ff;
   logic [PICK_W-1:0]   pick_ff;
   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic [COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [LVL_W-1:0]    level_ff, level_in;
   logic                finished_ff, finished_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [CELL_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [2:0]          scan_ff, scan_in;
   logic [3:0]          vis_bits_ff, vis_bits_in;

   // Memories and their registered read data.
   logic                vis_mem [CELLS];
   logic                vis_rd_ff;
   logic [STK_W-1:0]    stk_mem [STACK_DEPTH];
   logic [STK_W-1:0]    stk_rd_ff;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [EV_W-1:0]     ev_ff, ev_in;
   logic [COORD_W-1:0]  o_row_ff, o_row_in;
   logic [COORD_W-1:0]  o_col_ff, o_col_in;
   logic [COORD_W-1:0]  o_wrow_ff, o_wrow_in;
   logic [COORD_W-1:0]  o_wcol_ff, o_wcol_in;
   logic [OP_W-1:0]     o_op_ff, o_op_in;

   // Neighbor logic.
   logic [CMP_W-1:0]    rows_eff, cols_eff, cr, cc, rows_ext, cols_ext;
   logic [CMP_W-1:0]    srow_ext, scol_ext;
   logic [ROW_W-1:0]    st_row;
   logic [COL_W-1:0]    st_col;
   logic [CELL_W-1:0]   st_addr;
   logic [ROW_W-1:0]    cand_row [4];
   logic [COL_W-1:0]    cand_col [4];
   logic [ROW_W-1:0]    wall_row [4];
   logic [COL_W-1:0]    wall_col [4];
   logic [CELL_W-1:0]   cand_addr [4];
   logic [3:0]          in_rng, avail;
   logic [2:0]          cnt;
   logic [1:0]          idx, seen, sel_k;
   logic                found;
   logic [OP_W:0]       op_plus1, op_plus2;
   logic [OP_W-1:0]     op_sat1, op_sat2;
   logic                out_free;
   logic                any_commit;

   // Memory port controls.
   logic                vis_we, vis_wd, vis_re;
   logic [CELL_W-1:0]   vis_wa, vis_ra;
   logic [LVL_W-1:0]    pop_level;

   assign rows_ext = CMP_W'(rows_cfg_ff);
   assign cols_ext = CMP_W'(cols_cfg_ff);
   assign rows_eff = (rows_ext < CMP_W'(3)) ? CMP_W'(3) :
                     (rows_ext > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : rows_ext;
   assign cols_eff = (cols_ext < CMP_W'(3)) ? CMP_W'(3) :
                     (cols_ext > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS) : cols_ext;
   assign cr = CMP_W'(cur_row_ff);
   assign cc = CMP_W'(cur_col_ff);

   // Start cell, clamped to the largest grid (MAX_ROWS-1, MAX_COLS-1).
   assign srow_ext = CMP_W'(srow_cfg_ff);
   assign scol_ext = CMP_W'(scol_cfg_ff);
   assign st_row   = (srow_ext > CMP_W'(MAX_ROWS - 1)) ? ROW_W'(MAX_ROWS - 1)
                                                       : ROW_W'(srow_cfg_ff);
   assign st_col   = (scol_ext > CMP_W'(MAX_COLS - 1)) ? COL_W'(MAX_COLS - 1)
                                                       : COL_W'(scol_cfg_ff);
   assign st_addr  = CELL_W'(st_row) * CELL_W'(MAX_COLS) + CELL_W'(st_col);

   // Neighbors in the order up, down, left, right. Out-of-range ones may wrap;
   // the border test masks them.
   assign cand_row[0] = cur_row_ff - ROW_W'(2);
   assign cand_row[1] = cur_row_ff + ROW_W'(2);
   assign cand_row[2] = cur_row_ff;
   assign cand_row[3] = cur_row_ff;
   assign cand_col[0] = cur_col_ff;
   assign cand_col[1] = cur_col_ff;
   assign cand_col[2] = cur_col_ff - COL_W'(2);
   assign cand_col[3] = cur_col_ff + COL_W'(2);
   assign wall_row[0] = cur_row_ff - ROW_W'(1);
   assign wall_row[1] = cur_row_ff + ROW_W'(1);
   assign wall_row[2] = cur_row_ff;
   assign wall_row[3] = cur_row_ff;
   assign wall_col[0] = cur_col_ff;
   assign wall_col[1] = cur_col_ff;
   assign wall_col[2] = cur_col_ff - COL_W'(1);
   assign wall_col[3] = cur_col_ff + COL_W'(1);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cand_addr[k] = CELL_W'(cand_row[k]) * CELL_W'(MAX_COLS) + CELL_W'(cand_col[k]);
      end
   end

   // A neighbor must sit strictly inside the border on both axes.
   always_comb begin
      in_rng[0] = (cr >= CMP_W'(3)) && (cr <= rows_eff) &&
                  (cc >= CMP_W'(1)) && (cc + CMP_W'(1) < cols_eff);
      in_rng[1] = (cr + CMP_W'(3) < rows_eff) &&
                  (cc >= CMP_W'(1)) && (cc + CMP_W'(1) < cols_eff);
      in_rng[2] = (cr >= CMP_W'(1)) && (cr + CMP_W'(1) < rows_eff) &&
                  (cc >= CMP_W'(3)) && (cc <= cols_eff);
      in_rng[3] = (cr >= CMP_W'(1)) && (cr + CMP_W'(1) < rows_eff) &&
                  (cc + CMP_W'(3) < cols_eff);
   end

   assign avail = in_rng & ~vis_bits_ff;
   assign cnt   = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);

   always_comb begin
      case (cnt)
         3'd4:    idx = pick_ff[1:0];
         3'd3:    idx = mod3(pick_ff);
         3'd2:    idx = {1'b0, pick_ff[0]};
         default: idx = 2'd0;
      endcase
   end

   // The pick is the idx-th available neighbor in scan order.
   always_comb begin
      seen  = 2'd0;
      sel_k = 2'd0;
      found = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (avail[k]) begin
            if (!found && seen == idx) begin
               sel_k = 2'(k);
               found = 1'b1;
            end
            seen = seen + 2'd1;
         end
      end
   end

   assign op_plus1 = (OP_W + 1)'(op_ff) + (OP_W + 1)'(1);
   assign op_plus2 = (OP_W + 1)'(op_ff) + (OP_W + 1)'(2);
   assign op_sat1  = (op_plus1 > (OP_W + 1)'(OP_MAX)) ? OP_MAX : op_plus1[OP_W-1:0];
   assign op_sat2  = (op_plus2 > (OP_W + 1)'(OP_MAX)) ? OP_MAX : op_plus2[OP_W-1:0];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign any_commit = cmd.commit_start | cmd.commit_done | cmd.commit_carve |
                       cmd.commit_overflow | cmd.commit_pop;
   assign pop_level  = level_ff - LVL_W'(1);

   // Visited map ports: one write, one registered read.
   always_comb begin
      vis_we = 1'b0;
      vis_wa = clr_addr_ff;
      vis_wd = 1'b0;
      if (cmd.clear_step) begin
         vis_we = 1'b1;
      end else if (cmd.commit_start) begin
         vis_we = 1'b1;
         vis_wa = st_addr;
         vis_wd = 1'b1;
      end else if (cmd.commit_carve) begin
         vis_we = 1'b1;
         vis_wa = cand_addr[sel_k];
         vis_wd = 1'b1;
      end
      vis_re = cmd.scan_step && (scan_ff != 3'd4);
      vis_ra = cand_addr[scan_ff[1:0]];
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_wa] <= vis_wd;
      end
      if (vis_re) begin
         vis_rd_ff <= vis_mem[vis_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_carve) begin
         stk_mem[level_ff[SP_W-1:0]] <= {cur_row_ff, cur_col_ff};
      end
      if (cmd.pop_read) begin
         stk_rd_ff <= stk_mem[pop_level[SP_W-1:0]];
      end
   end

   // Walk state next values.
   always_comb begin
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      level_in    = level_ff;
      finished_in = finished_ff;
      op_in       = op_ff;
      clr_addr_in = clr_addr_ff;
      scan_in     = scan_ff;
      vis_bits_in = vis_bits_ff;
      if (cmd.load_item) begin
         clr_addr_in = '0;
         scan_in     = 3'd0;
      end
      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + CELL_W'(1);
      end
      if (cmd.scan_step) begin
         scan_in = scan_ff + 3'd1;
         // Read data of the previous scan cycle lands one slot behind.
         if (scan_ff != 3'd0) begin
            vis_bits_in[scan_ff[1:0] - 2'd1] = vis_rd_ff;
         end
      end
      if (cmd.commit_start) begin
         cur_row_in  = st_row;
         cur_col_in  = st_col;
         level_in    = '0;
         finished_in = 1'b0;
         op_in       = '0;
      end
      if (cmd.commit_done) begin
         finished_in = 1'b1;
      end
      if (cmd.commit_carve) begin
         cur_row_in = cand_row[sel_k];
         cur_col_in = cand_col[sel_k];
         level_in   = level_ff + LVL_W'(1);
         op_in      = op_sat2;
      end
      if (cmd.commit_pop) begin
         cur_row_in = stk_rd_ff[STK_W-1:COL_W];
         cur_col_in = stk_rd_ff[COL_W-1:0];
         level_in   = pop_level;
         op_in      = op_sat1;
      end
   end

   // Result register next values.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ev_in        = ev_ff;
      o_row_in     = o_row_ff;
      o_col_in     = o_col_ff;
      o_wrow_in    = o_wrow_ff;
      o_wcol_in    = o_wcol_ff;
      o_op_in      = o_op_ff;
      if (any_commit) begin
         rsp_valid_in = 1'b1;
         o_row_in     = '0;
         o_col_in     = '0;
         o_wrow_in    = '0;
         o_wcol_in    = '0;
         o_op_in      = op_ff;
         ev_in        = EV_DONE;
         if (cmd.commit_start) begin
            ev_in    = EV_STARTED;
            o_row_in = to_coord(CMP_W'(st_row));
            o_col_in = to_coord(CMP_W'(st_col));
            o_op_in  = '0;
         end else if (cmd.commit_carve) begin
            ev_in     = EV_CARVED;
            o_row_in  = to_coord(CMP_W'(cand_row[sel_k]));
            o_col_in  = to_coord(CMP_W'(cand_col[sel_k]));
            o_wrow_in = to_coord(CMP_W'(wall_row[sel_k]));
            o_wcol_in = to_coord(CMP_W'(wall_col[sel_k]));
            o_op_in   = op_sat2;
         end else if (cmd.commit_overflow) begin
            ev_in    = EV_OVERFLOW;
            o_row_in = to_coord(cr);
            o_col_in = to_coord(cc);
         end else if (cmd.commit_pop) begin
            ev_in    = EV_BACKTRACK;
            o_row_in = to_coord(CMP_W'(stk_rd_ff[STK_W-1:COL_W]));
            o_col_in = to_coord(CMP_W'(stk_rd_ff[COL_W-1:0]));
            o_op_in  = op_sat1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= CSR_DATA_W'(64);
         cols_cfg_ff  <= CSR_DATA_W'(64);
         srow_cfg_ff  <= COORD_W'(1);
         scol_cfg_ff  <= COORD_W'(1);
         cur_row_ff   <= ROW_W'(1);
         cur_col_ff   <= COL_W'(1);
         level_ff     <= '0;
         finished_ff  <= 1'b1;
         op_ff        <= '0;
         clr_addr_ff  <= '0;
         scan_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_addr)
               CSR_ROW_COUNT: rows_cfg_ff <= csr_wr_data;
               CSR_COL_COUNT: cols_cfg_ff <= csr_wr_data;
               CSR_START_ROW: srow_cfg_ff <= csr_wr_data[COORD_W-1:0];
               CSR_START_COL: scol_cfg_ff <= csr_wr_data[COORD_W-1:0];
               default: begin
               end
            endcase
         end
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         level_ff     <= level_in;
         finished_ff  <= finished_in;
         op_ff        <= op_in;
         clr_addr_ff  <= clr_addr_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= req_tuser[0];
         pick_ff   <= req_tdata[PICK_W-1:0];
      end
      vis_bits_ff <= vis_bits_in;
      ev_ff       <= ev_in;
      o_row_ff    <= o_row_in;
      o_col_ff    <= o_col_in;
      o_wrow_ff   <= o_wrow_in;
      o_wcol_ff   <= o_wcol_in;
      o_op_ff     <= o_op_in;
   end

   assign sts.action      = action_ff;
   assign sts.finished    = finished_ff;
   assign sts.clear_last  = (clr_addr_ff == CELL_W'(CELLS - 1));
   assign sts.scan_last   = (scan_ff == 3'd4);
   assign sts.has_cand    = |avail;
   assign sts.stack_full  = (level_ff == LVL_W'(STACK_DEPTH));
   assign sts.stack_empty = (level_ff == '0);
   assign sts.out_free    = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ev_ff;
   assign rsp_tdata  = {4'd0, o_op_ff, o_wcol_ff, o_wrow_ff, o_col_ff, o_row_ff};

endmodule

@@ design/maze_backtracker_step_unit.sv @@
// ----------------------------------------------------------------------------
// maze_backtracker_step_unit: randomized depth-first maze carver, one step per word
// Top level joining the sequencing controller and the storage datapath.
// ----------------------------------------------------------------------------
// Each request word is handled one at a time and answered by exactly one
// response word. A carving step or an overflow report scans the four
// neighbors and then commits its result; a backtrack adds a pop state, and a
// done report comes after the scan finds no open neighbor and an empty
// stack, or straight from dispatch once the maze is finished. The four
// neighbor bits are read one per cycle through the single read port of the
// visited map, and a backtrack adds one registered read of the path stack. A
// start word clears every entry of the visited map one entry per cycle;
// steps before the first start report done without touching the map. A result
// is committed only when the response register is free, so a response still
// waiting on rsp_tready holds back the result of the next word. The response
// register lets a new word be accepted while the previous response still waits
// on rsp_tready. Configuration writes are taken in any cycle and should be made
// while no word is in flight.
module maze_backtracker_step_unit #(
   parameter int MAX_ROWS    = mbs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS    = mbs_pkg::DEF_MAX_COLS,
   parameter int STACK_DEPTH = mbs_pkg::DEF_STACK_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // random_pick[7:0]
   input  logic [mbs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action[0]
   input  logic [mbs_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cell_row[5:0], cell_col[11:6], wall_row[17:12], wall_col[23:18],
   // op_count[43:24], zero[47:44]
   output logic [mbs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // event_res[2:0]
   output logic [mbs_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                            csr_wr_en,
   input  logic [mbs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [mbs_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import mbs_pkg::*;

   mbs_cmd_type cmd;
   mbs_sts_type sts;

   mbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mbs_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   // At most one kind of result is committed in a cycle.
   a_one_commit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.commit_start, cmd.commit_done, cmd.commit_carve,
                cmd.commit_overflow, cmd.commit_pop}))
      else $error("more than one result committed in a cycle");

   // A result is only committed when the response register can take it.
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_start || cmd.commit_done || cmd.commit_carve ||
       cmd.commit_overflow || cmd.commit_pop) |-> sts.out_free)
      else $error("result committed over a pending response");

   // A word in work blocks the next one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new word accepted while one is in work");

endmodule
